@@ rtl/ket_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed entry table package
// Operation and status codes, controller states and the fixed width and reset
// value of the capacity register.
// ----------------------------------------------------------------------------
package ket_pkg;

  // Width and reset value of the capacity register.
  localparam int CAP_WIDTH = 4;
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 4'd8;

  // Requested operation.
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_GET    = 2'd3
  } op_e;

  // Result status.
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_DUP     = 2'd2,
    STAT_MISSING = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_SCAN  = 3'd1,
    S_EXEC  = 3'd2,
    S_SHIFT = 3'd3,
    S_DONE  = 3'd4
  } state_e;

endpackage
`default_nettype wire

@@ rtl/ket_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ket_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/ket_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed entry table controller
// Walks the entry memory to find keys, applies add, delete, update and get,
// and compacts the table after a delete by moving later entries down.
// ----------------------------------------------------------------------------
module ket_ctrl import ket_pkg::*; #(
  parameter int DEPTH       = 8,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 32,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int DW = KEY_WIDTH + VALUE_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [CAP_WIDTH-1:0]   cap_i,
  // Request side
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             op_i,
  input  wire logic [KEY_WIDTH-1:0]   key_i,
  input  wire logic [KEY_WIDTH-1:0]   new_key_i,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  // Entry memory
  output logic                        ram_rd_en_o,
  output logic [AW-1:0]               ram_rd_addr_o,
  input  wire logic [DW-1:0]          ram_rd_data_i,
  output logic                        ram_wr_en_o,
  output logic [AW-1:0]               ram_wr_addr_o,
  output logic [DW-1:0]               ram_wr_data_o,
  // Result side
  output logic                        res_valid_o,
  input  wire logic                   res_ready_i,
  output logic [1:0]                  res_status_o,
  output logic [VALUE_WIDTH-1:0]      res_found_o,
  output logic [CW-1:0]               res_count_o
);

  localparam int CMPW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;

  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [KEY_WIDTH-1:0]   nkey_q, nkey_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic                   pend_q, pend_d;
  logic [AW-1:0]          pend_addr_q, pend_addr_d;
  logic                   hit_q, hit_d;
  logic [AW-1:0]          hit_slot_q, hit_slot_d;
  logic [VALUE_WIDTH-1:0] hit_val_q, hit_val_d;
  logic                   nhit_q, nhit_d;
  logic [CW-1:0]          used_q, used_d;
  status_e                status_q, status_d;
  logic [VALUE_WIDTH-1:0] found_q, found_d;

  logic                   rd_more;
  logic                   walk_done;
  logic                   full;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  status_e                exec_status;

  // Walk bookkeeping and field split of the read data.
  assign rd_more   = idx_q < used_q;
  assign walk_done = !rd_more && !pend_q;
  assign rd_key    = ram_rd_data_i[DW-1:VALUE_WIDTH];
  assign rd_val    = ram_rd_data_i[VALUE_WIDTH-1:0];

  // The table is full at the configured capacity or at the memory depth.
  assign full = (CMPW'(used_q) >= CMPW'(cap_i)) || (used_q >= CW'(DEPTH));

  // Outcome of the operation once the walk has finished.
  always_comb begin
    case (op_q)
      OP_ADD:    exec_status = full ? STAT_FULL : (hit_q ? STAT_DUP : STAT_OK);
      OP_DELETE: exec_status = hit_q ? STAT_OK : STAT_MISSING;
      OP_UPDATE: exec_status = !hit_q ? STAT_MISSING : (nhit_q ? STAT_DUP : STAT_OK);
      OP_GET:    exec_status = hit_q ? STAT_OK : STAT_MISSING;
      default:   exec_status = STAT_MISSING;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (walk_done) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_q == OP_DELETE && hit_q) begin
          state_d = S_SHIFT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        if (walk_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake, memory control and result outputs.
  always_comb begin
    in_ready_o    = (state_q == S_IDLE);
    ram_rd_en_o   = (state_q == S_SCAN || state_q == S_SHIFT) && rd_more;
    ram_rd_addr_o = idx_q[AW-1:0];
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = pend_addr_q - AW'(1);
    ram_wr_data_o = ram_rd_data_i;
    case (state_q)
      S_EXEC: begin
        if (exec_status == STAT_OK && op_q == OP_ADD) begin
          ram_wr_en_o   = 1'b1;
          ram_wr_addr_o = used_q[AW-1:0];
          ram_wr_data_o = {key_q, val_q};
        end else if (exec_status == STAT_OK && op_q == OP_UPDATE) begin
          ram_wr_en_o   = 1'b1;
          ram_wr_addr_o = hit_slot_q;
          ram_wr_data_o = {nkey_q, val_q};
        end
      end
      S_SHIFT: begin
        // Each entry read is written back one slot lower.
        ram_wr_en_o = pend_q;
      end
      default: begin
        ram_wr_en_o = 1'b0;
      end
    endcase
    res_valid_o  = (state_q == S_DONE);
    res_status_o = status_q;
    res_found_o  = found_q;
    res_count_o  = used_q;
  end

  // Datapath and counters.
  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    nkey_d      = nkey_q;
    val_d       = val_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    hit_val_d   = hit_val_q;
    nhit_d      = nhit_q;
    used_d      = used_q;
    status_d    = status_q;
    found_d     = found_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = op_e'(op_i);
          key_d  = key_i;
          nkey_d = new_key_i;
          val_d  = value_i;
          idx_d  = '0;
          pend_d = 1'b0;
          hit_d  = 1'b0;
          nhit_d = 1'b0;
        end
      end
      S_SCAN: begin
        pend_d = rd_more;
        if (rd_more) begin
          idx_d       = idx_q + CW'(1);
          pend_addr_d = idx_q[AW-1:0];
        end
        // Compare the entry read in the previous cycle; keep the first match.
        if (pend_q) begin
          if (rd_key == key_q && !hit_q) begin
            hit_d      = 1'b1;
            hit_slot_d = pend_addr_q;
            hit_val_d  = rd_val;
          end
          if (rd_key == nkey_q) begin
            nhit_d = 1'b1;
          end
        end
      end
      S_EXEC: begin
        status_d = exec_status;
        found_d  = (op_q == OP_GET && hit_q) ? hit_val_q : '0;
        if (exec_status == STAT_OK && op_q == OP_ADD) begin
          used_d = used_q + CW'(1);
        end
        // Compaction starts with the entry just above the deleted one.
        idx_d  = CW'(hit_slot_q) + CW'(1);
        pend_d = 1'b0;
      end
      S_SHIFT: begin
        pend_d = rd_more;
        if (rd_more) begin
          idx_d       = idx_q + CW'(1);
          pend_addr_d = idx_q[AW-1:0];
        end
        if (walk_done) begin
          used_d = used_q - CW'(1);
        end
      end
      default: begin
        used_d = used_q;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
      nhit_q   <= 1'b0;
      used_q   <= '0;
      status_q <= STAT_OK;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pend_q   <= pend_d;
      hit_q    <= hit_d;
      nhit_q   <= nhit_d;
      used_q   <= used_d;
      status_q <= status_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    nkey_q      <= nkey_d;
    val_q       <= val_d;
    pend_addr_q <= pend_addr_d;
    hit_slot_q  <= hit_slot_d;
    hit_val_q   <= hit_val_d;
    found_q     <= found_d;
  end

  // The entry count never passes the memory depth.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // Only occupied slots are ever read.
  a_read_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_rd_en_o |-> (CW'(ram_rd_addr_o) < used_q))
    else $error("read of an unoccupied slot");

  // A compaction write lands inside the occupied range and never below slot zero.
  a_shift_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && ram_wr_en_o) |-> (pend_addr_q != '0 &&
      CW'(ram_wr_addr_o) < used_q))
    else $error("compaction write out of range");

  // A successful add grows the table by exactly one entry.
  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && op_q == OP_ADD && exec_status == STAT_OK) |=>
      (used_q == $past(used_q) + CW'(1)))
    else $error("add did not grow the table");

endmodule
`default_nettype wire

@@ rtl/keyed_entry_table_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed entry table unit
// Packed key/payload table with add, delete, update and get requests.
// ----------------------------------------------------------------------------
// Each request is answered by one result item carrying a status, the payload
// found by a get and the entry count after the request. Entries live in one
// memory with a registered read; every request walks the N occupied slots one
// read per cycle, and a delete then moves the later entries down before its
// result item is offered. One request is in work at a time; the result
// register lets the next request be accepted while a result waits to be taken.
// The capacity register may be written at any time the unit is idle, and the
// table also counts as full once it holds DEPTH entries.
module keyed_entry_table_unit import ket_pkg::*; #(
  parameter int DEPTH       = 8,
  parameter int KEY_WIDTH   = 16,
  parameter int VALUE_WIDTH = 32,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1),
  localparam int DW = KEY_WIDTH + VALUE_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Capacity register
  input  wire logic                   cfg_we_i,
  input  wire logic [CAP_WIDTH-1:0]   cfg_wdata_i,
  // Request channel
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             op_i,
  input  wire logic [KEY_WIDTH-1:0]   key_i,
  input  wire logic [KEY_WIDTH-1:0]   new_key_i,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  // Result channel
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [1:0]                  status_o,
  output logic [VALUE_WIDTH-1:0]      found_value_o,
  output logic [CW-1:0]               entry_count_o
);

  logic [CAP_WIDTH-1:0]   cap_q;
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             status_q;
  logic [VALUE_WIDTH-1:0] found_q;
  logic [CW-1:0]          count_q;

  logic                   ram_rd_en;
  logic [AW-1:0]          ram_rd_addr;
  logic [DW-1:0]          ram_rd_data;
  logic                   ram_wr_en;
  logic [AW-1:0]          ram_wr_addr;
  logic [DW-1:0]          ram_wr_data;

  logic                   res_valid;
  logic                   res_ready;
  logic [1:0]             res_status;
  logic [VALUE_WIDTH-1:0] res_found;
  logic [CW-1:0]          res_count;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Entry memory.
  ket_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // Request sequencer.
  ket_ctrl #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cap_i         (cap_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .key_i         (key_i),
    .new_key_i     (new_key_i),
    .value_i       (value_i),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_status_o  (res_status),
    .res_found_o   (res_found),
    .res_count_o   (res_count)
  );

  // Result register: takes a new item when empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      status_q <= res_status;
      found_q  <= res_found;
      count_q  <= res_count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_value_o = found_q;
  assign entry_count_o = count_q;

endmodule
`default_nettype wire
